/* sv/mlp_sigmoid_inference_defines.svh */
// Assertion macros used by the port-level checker of the MLP inference block.
// No dependencies.
`ifndef MLP_SIGMOID_INFERENCE_DEFINES_SVH
`define MLP_SIGMOID_INFERENCE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MLPS_ASSERT_IMPLY(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, disabled in reset
`define MLPS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* sv/mlps_pkg.sv */
// Types, constants and sigmoid table builder for the MLP inference block.
// No dependencies.
`timescale 1ns / 1ps

package mlps_pkg;

  localparam int MAX_NEURONS   = 64;
  localparam int NEURON_W      = 6;
  localparam int MAX_LAYERS    = 4;
  localparam int WEIGHT_DEPTH  = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
  localparam int BIAS_DEPTH    = (MAX_LAYERS - 1) * MAX_NEURONS;
  localparam int ACT_DEPTH     = 2 * MAX_NEURONS;
  localparam int SIG_LOG       = 8;
  localparam int SIG_DEPTH     = 1 << SIG_LOG;
  localparam int ACC_W         = 40;
  localparam int DRAIN_CYCLES  = 4;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_BIAS    = 2'd1;
  localparam logic [1:0] OP_FEATURE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] REG_LAYER_COUNT  = 3'd0;
  localparam logic [2:0] REG_INPUT_SIZE   = 3'd1;
  localparam logic [2:0] REG_HIDDEN1_SIZE = 3'd2;
  localparam logic [2:0] REG_HIDDEN2_SIZE = 3'd3;
  localparam logic [2:0] REG_OUTPUT_SIZE  = 3'd4;

  typedef struct packed {
    logic [1:0]          n_m1;
    logic [NEURON_W-1:0] in_m1;
    logic [NEURON_W-1:0] h1_m1;
    logic [NEURON_W-1:0] h2_m1;
    logic [NEURON_W-1:0] out_m1;
  } cfg_t;

  typedef struct packed {
    logic wr_weight;
    logic wr_bias;
    logic wr_feat;
  } load_cmd_t;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic                src_feat;
    logic                final_l;
    logic [1:0]          lidx;
    logic [NEURON_W-1:0] j;
    logic [NEURON_W-1:0] k;
  } mac_cmd_t;

  typedef logic [7:0] sig_table_t [SIG_DEPTH];

  function automatic logic [NEURON_W-1:0] size_m1(input cfg_t c, input logic [1:0] idx);
    if (idx == 2'd0) return c.in_m1;
    if (idx == c.n_m1) return c.out_m1;
    if (idx == 2'd1) return c.h1_m1;
    return c.h2_m1;
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // elaboration-time build of the Q0.8 sigmoid table over [-8,8)
  function automatic sig_table_t build_sig_table();
    sig_table_t  tbl;
    logic [63:0] one;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] base;
    logic [63:0] den;
    logic [63:0] s;
    int          t;
    logic [31:0] u;
    one  = 64'd1 << 30;
    r    = one;
    term = one;
    for (int k = 1; k <= 8; k++) begin
      term = udiv(term, 64'(256 * k));
      if (k % 2 == 1) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i < SIG_DEPTH; i++) begin
      t    = -2048 + (i << (12 - SIG_LOG));
      u    = 32'((t < 0) ? -t : t);
      e    = one;
      base = r;
      for (int b = 0; b < 12; b++) begin
        if (u[b]) e = q30_mul(e, base);
        base = q30_mul(base, base);
      end
      den = one + e;
      if (t >= 0) s = udiv(64'd512 * one + den, 64'd2 * den);
      else s = udiv(64'd512 * e + den, 64'd2 * den);
      if (s > 64'd255) s = 64'd255;
      tbl[i] = s[7:0];
    end
    return tbl;
  endfunction

endpackage

/* sv/mlps_cfg.sv */
// APB configuration registers with size and layer count clamping.
// Depends on mlps_pkg.
`timescale 1ns / 1ps

module mlps_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output mlps_pkg::cfg_t      cfg
);

  logic [2:0] layer_count;
  logic [6:0] input_size;
  logic [6:0] hidden1_size;
  logic [6:0] hidden2_size;
  logic [6:0] output_size;
  logic [2:0] ridx;
  logic       wr;

  assign ridx = paddr[4:2];
  assign wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count  <= 3'd3;
      input_size   <= 7'd64;
      hidden1_size <= 7'd64;
      hidden2_size <= 7'd64;
      output_size  <= 7'd10;
    end else if (wr) begin
      unique case (ridx)
        mlps_pkg::REG_LAYER_COUNT:  layer_count  <= pwdata[2:0];
        mlps_pkg::REG_INPUT_SIZE:   input_size   <= pwdata[6:0];
        mlps_pkg::REG_HIDDEN1_SIZE: hidden1_size <= pwdata[6:0];
        mlps_pkg::REG_HIDDEN2_SIZE: hidden2_size <= pwdata[6:0];
        mlps_pkg::REG_OUTPUT_SIZE:  output_size  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      mlps_pkg::REG_LAYER_COUNT:  prdata = {29'd0, layer_count};
      mlps_pkg::REG_INPUT_SIZE:   prdata = {25'd0, input_size};
      mlps_pkg::REG_HIDDEN1_SIZE: prdata = {25'd0, hidden1_size};
      mlps_pkg::REG_HIDDEN2_SIZE: prdata = {25'd0, hidden2_size};
      mlps_pkg::REG_OUTPUT_SIZE:  prdata = {25'd0, output_size};
      default:                    prdata = 32'd0;
    endcase
  end

  function automatic logic [5:0] clamp_m1(input logic [6:0] s);
    if (s == 7'd0) return 6'd0;
    if (s > 7'd64) return 6'd63;
    return 6'(s - 7'd1);
  endfunction

  always_comb begin
    if (layer_count < 3'd2) cfg.n_m1 = 2'd1;
    else if (layer_count > 3'd4) cfg.n_m1 = 2'd3;
    else cfg.n_m1 = 2'(layer_count - 3'd1);
    cfg.in_m1  = clamp_m1(input_size);
    cfg.h1_m1  = clamp_m1(hidden1_size);
    cfg.h2_m1  = clamp_m1(hidden2_size);
    cfg.out_m1 = clamp_m1(output_size);
  end

endmodule

/* sv/mlps_ctrl.sv */
// Controller: input handshake, load decode, forward-pass sequencer, result beat.
// Depends on mlps_pkg.
`timescale 1ns / 1ps

module mlps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  mlps_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  logic [1:0]             layer,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mlps_pkg::load_cmd_t    load,
  output mlps_pkg::mac_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t     state;
  logic [1:0] l;
  logic [5:0] j;
  logic [5:0] k;
  logic [1:0] dcnt;
  logic [5:0] insz_m1;
  logic [5:0] outsz_m1;
  logic       accept;
  logic       start;

  assign in_ready = (state == ST_IDLE) &&
                    !(out_valid && op == mlps_pkg::OP_FEATURE && last);
  assign accept   = in_valid && in_ready;
  assign start    = accept && op == mlps_pkg::OP_FEATURE && last;

  assign load.wr_weight = accept && op == mlps_pkg::OP_WEIGHT && layer != 2'd0;
  assign load.wr_bias   = accept && op == mlps_pkg::OP_BIAS && layer != 2'd0;
  assign load.wr_feat   = accept && op == mlps_pkg::OP_FEATURE;

  assign insz_m1  = mlps_pkg::size_m1(cfg, l - 2'd1);
  assign outsz_m1 = mlps_pkg::size_m1(cfg, l);

  assign cmd.valid    = (state == ST_RUN);
  assign cmd.first    = (k == 6'd0);
  assign cmd.last     = (k == insz_m1);
  assign cmd.src_feat = (l == 2'd1);
  assign cmd.final_l  = (l == cfg.n_m1);
  assign cmd.lidx     = l - 2'd1;
  assign cmd.j        = j;
  assign cmd.k        = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      l         <= 2'd1;
      j         <= '0;
      k         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            l     <= 2'd1;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k == insz_m1) begin
            k <= '0;
            if (j == outsz_m1) begin
              j     <= '0;
              dcnt  <= '0;
              state <= ST_DRAIN;
            end else begin
              j <= j + 6'd1;
            end
          end else begin
            k <= k + 6'd1;
          end
        end
        ST_DRAIN: begin
          if (dcnt == 2'(mlps_pkg::DRAIN_CYCLES - 1)) begin
            if (l == cfg.n_m1) begin
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              l     <= l + 2'd1;
              state <= ST_RUN;
            end
          end else begin
            dcnt <= dcnt + 2'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/mlps_dp.sv */
// Datapath: weight, bias, feature and activation memories, MAC pipeline,
// rounding, sigmoid lookup and argmax. Depends on mlps_pkg.
`timescale 1ns / 1ps

module mlps_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  mlps_pkg::load_cmd_t   load,
  input  logic [1:0]            layer,
  input  logic [5:0]            row,
  input  logic [5:0]            col,
  input  logic signed [15:0]    value,
  input  mlps_pkg::mac_cmd_t    cmd,
  output logic [5:0]            class_index
);

  localparam mlps_pkg::sig_table_t SIG_TABLE = mlps_pkg::build_sig_table();

  logic signed [15:0] wmem [mlps_pkg::WEIGHT_DEPTH];
  logic signed [15:0] bmem [mlps_pkg::BIAS_DEPTH];
  logic signed [15:0] fmem [mlps_pkg::MAX_NEURONS];
  logic signed [15:0] amem [mlps_pkg::ACT_DEPTH];

  logic [1:0]                  wl;
  mlps_pkg::mac_cmd_t          s1, s2, s3, s4;
  logic signed [15:0]          w_q, b_q, f_q, a_q, a_sel, b2;
  logic signed [31:0]          prod2;
  logic signed [mlps_pkg::ACC_W-1:0] acc, acc_base, rnd;
  logic signed [15:0]          xsat, sat, xoff;
  logic [mlps_pkg::SIG_LOG-1:0] sidx;
  logic [7:0]                  entry;
  logic [7:0]                  best_val;

  assign wl = layer - 2'd1;

  always_ff @(posedge clk) begin
    if (load.wr_weight) wmem[{wl, row, col}] <= value;
    w_q <= wmem[{cmd.lidx, cmd.j, cmd.k}];
  end

  always_ff @(posedge clk) begin
    if (load.wr_bias) bmem[{wl, row}] <= value;
    b_q <= bmem[{cmd.lidx, cmd.j}];
  end

  always_ff @(posedge clk) begin
    if (load.wr_feat) fmem[col] <= value;
    f_q <= fmem[cmd.k];
  end

  always_ff @(posedge clk) begin
    if (s4.valid && s4.last) amem[{~s4.lidx[0], s4.j}] <= {8'd0, entry};
    a_q <= amem[{cmd.lidx[0], cmd.k}];
  end

  assign a_sel    = s1.src_feat ? f_q : a_q;
  assign acc_base = s2.first ? {{(mlps_pkg::ACC_W - 24){b2[15]}}, b2, 8'd0} : acc;
  assign rnd      = (acc + mlps_pkg::ACC_W'(128)) >>> 8;

  always_comb begin
    if (rnd > mlps_pkg::ACC_W'(32767)) sat = 16'sh7fff;
    else if (rnd < -mlps_pkg::ACC_W'(32768)) sat = -16'sh8000;
    else sat = rnd[15:0];
  end

  assign xoff = xsat + 16'sd2048;

  always_comb begin
    if (xsat < -16'sd2048) sidx = '0;
    else if (xsat >= 16'sd2048) sidx = '1;
    else sidx = xoff[11 -: mlps_pkg::SIG_LOG];
  end

  assign entry = SIG_TABLE[sidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else begin
      s1 <= cmd;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= w_q * a_sel;
    if (s1.valid && s1.first) b2 <= b_q;
    if (s2.valid) acc <= acc_base + {{(mlps_pkg::ACC_W - 32){prod2[31]}}, prod2};
    xsat <= sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_index <= '0;
      best_val    <= '0;
    end else if (s4.valid && s4.last && s4.final_l) begin
      if (s4.j == 6'd0 || entry > best_val) begin
        class_index <= s4.j;
        best_val    <= entry;
      end
    end
  end

endmodule

/* sv/mlp_sigmoid_inference.sv */
// Multilayer perceptron inference block, sigmoid activations, argmax result.
// Input channel: op/layer/row/col/value/last beats on in_valid/in_ready.
//   Weight and bias beats fill their memories; feature beats fill the input
//   buffer, and a feature beat with last set starts a forward pass.
// Output channel: one class_index beat on out_valid/out_ready per pass.
// A pass runs each layer as n_in*n_out products and a pipeline drain; its
//   pace is set by the single multiply-accumulate unit and the weight memory
//   read port, one weight per cycle.
// Load beats are taken every cycle while no pass runs, also while a result
//   waits; a starting feature beat waits until the pending result is taken.
// Configuration: APB registers layer_count, input_size, hidden1_size,
//   hidden2_size, output_size at byte addresses 0, 4, 8, 12, 16.
// Reset (rst, synchronous): registers return to 3/64/64/64/10, no result
//   pending; stored weights, biases and features are undefined until loaded.
// A stalled receiver holds class_index steady until the beat is taken.
// Depends on mlps_pkg, mlps_cfg, mlps_ctrl, mlps_dp.
`timescale 1ns / 1ps

module mlp_sigmoid_inference (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [1:0]         layer,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [15:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         class_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mlps_pkg::cfg_t      cfg;
  mlps_pkg::load_cmd_t load;
  mlps_pkg::mac_cmd_t  cmd;

  assign pready = 1'b1;

  mlps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mlps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .layer     (layer),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .load      (load),
    .cmd       (cmd)
  );

  mlps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .layer       (layer),
    .row         (row),
    .col         (col),
    .value       (value),
    .cmd         (cmd),
    .class_index (class_index)
  );

endmodule

/* sv/mlps_checker.sv */
// Port-level checker for the MLP inference block, bound to the top level.
// Depends on mlps_pkg and mlp_sigmoid_inference_defines.svh.
`timescale 1ns / 1ps
`include "mlp_sigmoid_inference_defines.svh"

module mlps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic [1:0]  op,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  class_index
);

  `MLPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(class_index), "result beat dropped or changed while stalled")
  `MLPS_ASSERT_IMPLY(a_reset_clear, clk, rst, $past(rst), !out_valid, "result pending right after reset")
  `MLPS_ASSERT_IMPLY(a_no_start_pending, clk, rst, out_valid && op == mlps_pkg::OP_FEATURE && last, !in_ready, "pass started while result pending")
  `MLPS_ASSERT_NEXT(a_no_back_result, clk, rst, out_valid && out_ready, !out_valid, "result beat repeated")

endmodule

bind mlp_sigmoid_inference mlps_checker u_chk (.*);
